// ===== design/wgc_pkg.sv =====
// shared types, constants and the quarter-wave sine table for the waveform channel
// no dependencies

package wgc_pkg;

    localparam int PHASE_BITS_DEF = 32;
    localparam int LEVEL_BITS_DEF = 16;

    localparam int SINE_DEPTH     = 256;
    localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);
    localparam int TURN_BITS      = 24;
    localparam int SINE_BITS      = 25;
    localparam int WAVE_BITS      = 26;

    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int STEP_BITS      = 32;

    localparam logic [STEP_BITS-1:0] PHASE_STEP_RST = 32'd42949673;

    typedef enum logic [1:0] {
        MODE_CONST = 2'd0,
        MODE_SINE  = 2'd1,
        MODE_TRI   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE  = 3'd0,
        CFG_LOW   = 3'd1,
        CFG_HIGH  = 3'd2,
        CFG_STEP  = 3'd3,
        CFG_CONST = 3'd4
    } t_cfg_idx;

    typedef logic [SINE_BITS-1:0] t_sine_tab [0:SINE_DEPTH];

    localparam longint unsigned Q24_ONE = 64'd16777216;
    localparam longint unsigned Q30_ONE = 64'd1073741824;
    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598668;
    localparam longint unsigned K5 = 64'd85569306;
    localparam longint unsigned K7 = 64'd5026994;
    localparam longint unsigned K9 = 64'd172272;

    // odd degree-9 polynomial in q30, rounded to q24 and capped at one
    function automatic t_sine_tab f_build_sine();
        t_sine_tab         tab;
        longint unsigned   u;
        longint unsigned   u2;
        longint unsigned   t;
        longint unsigned   r;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            u  = (longint'(k) * Q30_ONE) / SINE_DEPTH;
            u2 = (u * u) >> 30;
            t  = K9;
            t  = K7 - ((u2 * t) >> 30);
            t  = K5 - ((u2 * t) >> 30);
            t  = K3 - ((u2 * t) >> 30);
            t  = K1 - ((u2 * t) >> 30);
            r  = (((u * t) >> 30) + 64'd32) >> 6;
            if (r > Q24_ONE) begin
                r = Q24_ONE;
            end
            tab[k] = r[SINE_BITS-1:0];
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_build_sine();

endpackage

// ===== design/wgc_wave.sv =====
// waveform shape: turn fraction to a signed q24 sample, sine from the quarter table or triangle
// depends on wgc_pkg

module wgc_wave import wgc_pkg::*; (
    input  logic [TURN_BITS-1:0]        i_turn,
    input  t_mode                       i_mode,
    output logic signed [WAVE_BITS-1:0] o_wave
);

    logic [1:0]               w_quad;
    logic [SINE_IDX_BITS-1:0] w_idx;
    logic [SINE_IDX_BITS:0]   w_tab_idx;
    logic [SINE_BITS-1:0]     w_tab_val;
    logic signed [WAVE_BITS-1:0] w_sine;
    logic [TURN_BITS-1:0]     w_dist;
    logic signed [WAVE_BITS:0]   w_tri_full;
    logic signed [WAVE_BITS-1:0] w_tri;

    assign w_quad    = i_turn[TURN_BITS-1 -: 2];
    assign w_idx     = i_turn[TURN_BITS-3 -: SINE_IDX_BITS];
    assign w_tab_idx = w_quad[0] ? ((SINE_IDX_BITS+1)'(SINE_DEPTH) - {1'b0, w_idx})
                                 : {1'b0, w_idx};
    assign w_tab_val = SINE_TAB[w_tab_idx];
    assign w_sine    = w_quad[1] ? -$signed({1'b0, w_tab_val}) : $signed({1'b0, w_tab_val});

    // distance from phase zero, at most half a turn
    assign w_dist     = i_turn[TURN_BITS-1] ? (TURN_BITS'(0) - i_turn) : i_turn;
    assign w_tri_full = $signed({1'b0, w_dist, 2'b00}) - (WAVE_BITS+1)'(Q24_ONE);
    assign w_tri      = w_tri_full[WAVE_BITS-1:0];

    assign o_wave = (i_mode == MODE_TRI) ? w_tri : w_sine;

endmodule

// ===== design/waveform_generator_channel.sv =====
// top level of one waveform generator channel: config registers, phase accumulator,
// three-stage level pipeline with output register
// depends on wgc_pkg and wgc_wave
//
//  channel   signals                                   moves
//  in        i_in_valid / o_in_ready, i_restart        one tick word
//  out       o_out_valid / i_out_ready, o_level, o_mode_error   one level word
//  cfg       i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data  one register write
//
// one tick word accepted per cycle while o_in_ready is high; its level word passes r_wave, r_prod, then r_level
// stages: phase and table lookup, multiply by swing, sum round and saturate
// reset clears the phase, the config registers and all stage valids; no clearing pass
// a stalled output fills the empty stages before o_in_ready falls
// o_cfg_ready is always high

module waveform_generator_channel import wgc_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_restart,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [LEVEL_BITS-1:0] o_level,
    output logic                         o_mode_error,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int STEP_W = (PHASE_BITS < STEP_BITS) ? PHASE_BITS : STEP_BITS;
    localparam int PROD_W = LEVEL_BITS + 1 + WAVE_BITS;
    localparam int NUM_W  = PROD_W + 1;
    localparam int Q_W    = NUM_W - 25;

    t_mode                         r_mode;
    logic signed [LEVEL_BITS-1:0]  r_lo;
    logic signed [LEVEL_BITS-1:0]  r_hi;
    logic [STEP_W-1:0]             r_step;
    logic signed [LEVEL_BITS-1:0]  r_const;
    logic [PHASE_BITS-1:0]         r_phase;

    logic                          r_v1;
    logic                          r_v2;
    logic                          r_vo;
    logic signed [WAVE_BITS-1:0]   r_wave;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [LEVEL_BITS:0]    r_sum;
    logic signed [LEVEL_BITS-1:0]  r_level;
    logic                          r_err;

    logic                          w_ld_o;
    logic                          w_ld_2;
    logic                          w_ld_1;
    logic                          w_take;
    logic [PHASE_BITS-1:0]         w_cur_phase;
    logic [TURN_BITS-1:0]          w_turn;
    logic signed [WAVE_BITS-1:0]   w_wave;
    logic signed [LEVEL_BITS:0]    w_diff;
    logic signed [NUM_W-1:0]       w_num;
    logic signed [Q_W-1:0]         w_q;
    logic                          w_ovf;
    logic signed [LEVEL_BITS-1:0]  w_sat;
    logic signed [LEVEL_BITS-1:0]  n_level;
    logic                          n_err;

    // ---------------- config port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_CONST;
            r_lo    <= '0;
            r_hi    <= '0;
            r_step  <= PHASE_STEP_RST[STEP_W-1:0];
            r_const <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:  r_mode  <= t_mode'(i_cfg_data[1:0]);
                CFG_LOW:   r_lo    <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_HIGH:  r_hi    <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                CFG_CONST: r_const <= i_cfg_data[LEVEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- stage flow
    assign w_ld_o     = !r_vo || i_out_ready;
    assign w_ld_2     = !r_v2 || w_ld_o;
    assign w_ld_1     = !r_v1 || w_ld_2;
    assign o_in_ready = w_ld_1;
    assign w_take     = i_in_valid && w_ld_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_ld_1) begin
                r_v1 <= i_in_valid;
            end
            if (w_ld_2) begin
                r_v2 <= r_v1;
            end
            if (w_ld_o) begin
                r_vo <= r_v2;
            end
        end
    end

    // ---------------- stage 1: phase and shape
    assign w_cur_phase = i_restart ? '0 : r_phase;

    generate
        if (PHASE_BITS >= TURN_BITS) begin : g_turn_cut
            assign w_turn = w_cur_phase[PHASE_BITS-1 -: TURN_BITS];
        end else begin : g_turn_pad
            assign w_turn = {w_cur_phase, {(TURN_BITS-PHASE_BITS){1'b0}}};
        end
    endgenerate

    wgc_wave u_wave (
        .i_turn (w_turn),
        .i_mode (r_mode),
        .o_wave (w_wave)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_take) begin
            r_phase <= w_cur_phase + PHASE_BITS'(r_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_wave <= w_wave;
        end
    end

    // ---------------- stage 2: swing multiply
    assign w_diff = $signed({r_hi[LEVEL_BITS-1], r_hi}) - $signed({r_lo[LEVEL_BITS-1], r_lo});

    always_ff @(posedge i_clk) begin
        if (r_v1 && w_ld_2) begin
            r_prod <= w_diff * r_wave;
            r_sum  <= $signed({r_hi[LEVEL_BITS-1], r_hi}) + $signed({r_lo[LEVEL_BITS-1], r_lo});
        end
    end

    // ---------------- stage 3: centre, round, saturate
    assign w_num = $signed({{(NUM_W-LEVEL_BITS-1-TURN_BITS){r_sum[LEVEL_BITS]}}, r_sum,
                            {TURN_BITS{1'b0}}})
                 + $signed({r_prod[PROD_W-1], r_prod})
                 + $signed(NUM_W'(Q24_ONE));
    assign w_q   = w_num[NUM_W-1:25];
    assign w_ovf = !((&w_q[Q_W-1:LEVEL_BITS-1]) || !(|w_q[Q_W-1:LEVEL_BITS-1]));
    assign w_sat = w_ovf ? (w_q[Q_W-1] ? {1'b1, {(LEVEL_BITS-1){1'b0}}}
                                       : {1'b0, {(LEVEL_BITS-1){1'b1}}})
                         : w_q[LEVEL_BITS-1:0];

    always_comb begin
        unique case (r_mode)
            MODE_CONST: begin
                n_level = r_const;
                n_err   = 1'b0;
            end
            MODE_SINE, MODE_TRI: begin
                n_level = w_sat;
                n_err   = 1'b0;
            end
            MODE_NONE: begin
                n_level = '0;
                n_err   = 1'b1;
            end
            default: begin
                n_level = '0;
                n_err   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && w_ld_o) begin
            r_level <= n_level;
            r_err   <= n_err;
        end
    end

    assign o_out_valid  = r_vo;
    assign o_level      = r_level;
    assign o_mode_error = r_err;

endmodule

// ===== sim/wgc_level_checker.sv =====
// level word checker for the waveform generator channel: follows register writes,
// predicts the level word of every accepted tick and compares it with the output
// depends on wgc_pkg

module wgc_level_checker import wgc_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic                             i_restart,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic signed [LEVEL_BITS_DEF-1:0] i_level,
    input  logic                             i_mode_error,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]          i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]         i_cfg_data,
    output int                               o_pending,
    output int                               o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LB         = LEVEL_BITS_DEF;
    localparam int     PB         = PHASE_BITS_DEF;
    localparam int     REPORT_MAX = 10;
    localparam longint UNIT_Q24   = 64'sd16777216;
    localparam longint LEVEL_TOP  = (64'sd1 <<< (LB - 1)) - 64'sd1;
    localparam longint unsigned HORNER_COEF [4] = '{K7, K5, K3, K1};

    typedef struct packed {
        logic signed [LB-1:0] level;
        logic                 mode_error;
    } t_level_word;

    t_level_word          level_due_q [$];
    logic [SINE_BITS-1:0] quarter_wave [0:SINE_DEPTH];
    t_mode                mode_r;
    logic signed [LB-1:0] low_r;
    logic signed [LB-1:0] high_r;
    logic signed [LB-1:0] const_r;
    logic [STEP_BITS-1:0] step_r;
    logic [PB-1:0]        phase_r;
    int                   fail_count = 0;
    int                   word_count = 0;

    // quarter-wave sine from an odd polynomial, q30 horner steps, rounded to q24
    initial begin
        longint unsigned u;
        longint unsigned u2;
        longint unsigned poly;
        longint unsigned r;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            u    = (longint'(k) * Q30_ONE) / SINE_DEPTH;
            u2   = (u * u) >> 30;
            poly = K9;
            for (int c = 0; c < 4; c++) begin
                poly = HORNER_COEF[c] - ((u2 * poly) >> 30);
            end
            r = (((u * poly) >> 30) + 64'd32) >> 6;
            if (r > Q24_ONE) begin
                r = Q24_ONE;
            end
            quarter_wave[k] = r[SINE_BITS-1:0];
        end
    end

    function automatic t_level_word predict_level(logic [PB-1:0] phase);
        logic [TURN_BITS-1:0]     turn;
        logic [SINE_IDX_BITS-1:0] idx;
        longint                   turn_l;
        longint                   wave;
        longint                   lvl;
        t_level_word              word;
        turn            = phase[PB-1 -: TURN_BITS];
        idx             = turn[TURN_BITS-3 -: SINE_IDX_BITS];
        turn_l          = turn;
        wave            = 0;
        lvl             = 0;
        word.mode_error = 1'b0;
        case (mode_r)
            MODE_CONST: lvl = const_r;
            MODE_SINE, MODE_TRI: begin
                if (mode_r == MODE_SINE) begin
                    if (turn[TURN_BITS-2]) begin
                        wave = quarter_wave[SINE_DEPTH - idx];
                    end else begin
                        wave = quarter_wave[idx];
                    end
                    if (turn[TURN_BITS-1]) begin
                        wave = -wave;
                    end
                end else if (turn[TURN_BITS-1]) begin
                    wave = 4 * (UNIT_Q24 - turn_l) - UNIT_Q24;
                end else begin
                    wave = 4 * turn_l - UNIT_Q24;
                end
                // centre plus half swing times wave, rounded half up
                lvl = ((longint'(high_r) + longint'(low_r)) * UNIT_Q24
                      + (longint'(high_r) - longint'(low_r)) * wave + UNIT_Q24) >>> 25;
            end
            default: begin
                lvl             = 0;
                word.mode_error = 1'b1;
            end
        endcase
        if (lvl > LEVEL_TOP) begin
            lvl = LEVEL_TOP;
        end else if (lvl < -LEVEL_TOP - 1) begin
            lvl = -LEVEL_TOP - 1;
        end
        word.level = lvl[LB-1:0];
        return word;
    endfunction

    always @(posedge i_clk) begin
        t_level_word want;
        if (!i_rst_n) begin
            mode_r  = MODE_CONST;
            low_r   = '0;
            high_r  = '0;
            const_r = '0;
            step_r  = PHASE_STEP_RST;
            phase_r = '0;
            level_due_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                word_count++;
                if (level_due_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("level word %0d not expected: level %0d err %0b",
                                 word_count, i_level, i_mode_error);
                    end
                end else begin
                    want = level_due_q.pop_front();
                    if (i_level !== want.level || i_mode_error !== want.mode_error) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("level word %0d: expected %0d err %0b, got %0d err %0b",
                                     word_count, want.level, want.mode_error,
                                     i_level, i_mode_error);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:  mode_r  = t_mode'(i_cfg_data[1:0]);
                    CFG_LOW:   low_r   = i_cfg_data[LB-1:0];
                    CFG_HIGH:  high_r  = i_cfg_data[LB-1:0];
                    CFG_STEP:  step_r  = i_cfg_data[STEP_BITS-1:0];
                    CFG_CONST: const_r = i_cfg_data[LB-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_restart) begin
                    phase_r = '0;
                end
                level_due_q.push_back(predict_level(phase_r));
                phase_r = phase_r + step_r[PB-1:0];
            end
        end
        o_pending    <= level_due_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== sim/tb_waveform_generator_channel.sv =====
// testbench top for the waveform generator channel: clock, reset, tick and register
// stimulus, output back-pressure and the verdict
// depends on wgc_pkg, waveform_generator_channel and wgc_level_checker

module tb_waveform_generator_channel;
    timeunit 1ns;
    timeprecision 1ps;
    import wgc_pkg::*;

    localparam int SECTION_TICKS   = 105;
    localparam int RESTART_PCT     = 4;
    localparam int HOLD_CYCLES     = 60;
    localparam int RECOVERY_CYCLES = 8;

    localparam logic signed [LEVEL_BITS_DEF-1:0] LEVEL_MAX = 16'sh7FFF;
    localparam logic signed [LEVEL_BITS_DEF-1:0] LEVEL_MIN = 16'sh8000;
    localparam logic [STEP_BITS-1:0] STEP_QUARTER = 32'h4000_0000;
    localparam logic [STEP_BITS-1:0] STEP_HALF    = 32'h8000_0000;
    localparam logic [STEP_BITS-1:0] STEP_FULL    = 32'hFFFF_FFFF;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd5;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    logic                             o_in_ready;
    logic                             i_restart   = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic signed [LEVEL_BITS_DEF-1:0] o_level;
    logic                             o_mode_error;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]         i_cfg_data  = '0;

    int pending_words;
    int fail_count;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int hold_ask     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    waveform_generator_channel i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_level      (o_level),
        .o_mode_error (o_mode_error),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    wgc_level_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_level      (o_level),
        .i_mode_error (o_mode_error),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending_words),
        .o_fail_count (fail_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // output side: random stalls, plus a long hold whenever one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    task automatic cfg_put(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (RECOVERY_CYCLES) @(posedge i_clk);
    endtask

    // unused upper data bits carry junk, the block must mask them
    task automatic load_settings(t_mode mode, logic signed [LEVEL_BITS_DEF-1:0] lo,
                                 logic signed [LEVEL_BITS_DEF-1:0] hi,
                                 logic [STEP_BITS-1:0] step,
                                 logic signed [LEVEL_BITS_DEF-1:0] cst);
        logic [CFG_DATA_BITS-1:0] junk;
        junk = $urandom;
        wait_idle();
        cfg_put(CFG_MODE,  {junk[CFG_DATA_BITS-1:2], mode});
        cfg_put(CFG_LOW,   {junk[CFG_DATA_BITS-1:LEVEL_BITS_DEF], lo});
        cfg_put(CFG_HIGH,  {junk[CFG_DATA_BITS-1:LEVEL_BITS_DEF], hi});
        cfg_put(CFG_STEP,  step);
        cfg_put(CFG_CONST, {junk[CFG_DATA_BITS-1:LEVEL_BITS_DEF], cst});
        i_cfg_valid <= 1'b0;
    endtask

    // each cycle idles with the sender's idle share before the word is offered
    task automatic send_tick(logic restart);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic logic signed [LEVEL_BITS_DEF-1:0] pick_level();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0: return LEVEL_MAX;
            1: return LEVEL_MIN;
            default: return r[LEVEL_BITS_DEF-1:0];
        endcase
    endfunction

    function automatic logic [STEP_BITS-1:0] pick_step();
        case ($urandom_range(7))
            0: return '0;
            1: return STEP_FULL;
            2: return STEP_QUARTER;
            3: return STEP_HALF;
            4, 5: return $urandom_range(32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_mode mode_pick;
        int    roll;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults after reset
        send_tick(1'b0);
        send_tick(1'b1);
        load_settings(MODE_CONST, 0, 0, PHASE_STEP_RST, LEVEL_MAX);
        send_tick(1'b0);
        load_settings(MODE_CONST, 0, 0, PHASE_STEP_RST, LEVEL_MIN);
        send_tick(1'b1);
        // quarter-turn steps land on every quadrant boundary
        load_settings(MODE_SINE, LEVEL_MIN, LEVEL_MAX, STEP_QUARTER, 0);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        // full-scale step wraps the phase
        load_settings(MODE_SINE, LEVEL_MIN, LEVEL_MAX, STEP_FULL, 0);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        load_settings(MODE_TRI, LEVEL_MIN, LEVEL_MAX, STEP_QUARTER, 0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        // swapped bounds invert the swing
        load_settings(MODE_TRI, LEVEL_MAX, LEVEL_MIN, STEP_HALF, 0);
        send_tick(1'b1);
        send_tick(1'b0);
        load_settings(MODE_NONE, LEVEL_MIN, LEVEL_MAX, STEP_QUARTER, LEVEL_MAX);
        send_tick(1'b1);
        send_tick(1'b0);
        // writes past the register list change nothing
        wait_idle();
        for (int k = CFG_SPARE; k < (1 << CFG_IDX_BITS); k++) begin
            cfg_put(k[CFG_IDX_BITS-1:0], $urandom);
        end
        i_cfg_valid <= 1'b0;
        send_tick(1'b0);
        // zero step holds the phase
        load_settings(MODE_SINE, LEVEL_MIN, LEVEL_MIN, '0, 0);
        repeat (2) send_tick(1'b0);

        for (int plan = 0; plan < 3; plan++) begin
            in_idle_pct = (plan == 0) ? 27 : (plan == 1) ? 55 : 0;
            out_idle_pct <= (plan == 0) ? 55 : (plan == 1) ? 27 : 0;
            for (int sect = 0; sect < 3; sect++) begin
                roll = $urandom_range(9);
                if (roll == 0) begin
                    mode_pick = MODE_CONST;
                end else if (roll < 5) begin
                    mode_pick = MODE_SINE;
                end else if (roll < 9) begin
                    mode_pick = MODE_TRI;
                end else begin
                    mode_pick = MODE_NONE;
                end
                load_settings(mode_pick, pick_level(), pick_level(), pick_step(), pick_level());
                if (sect == 1) begin
                    hold_ask <= hold_ask + 1;
                end
                repeat (SECTION_TICKS) send_tick($urandom_range(99) < RESTART_PCT);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("waveform_generator_channel verification clean");
        end else begin
            $display("waveform_generator_channel verification failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("waveform_generator_channel verification failed");
        $finish;
    end

endmodule
